### rtl/core/tfn_pkg.sv
// Shared constants for the triangle face normal pipeline.
package tfn_pkg;

  localparam int COORD_WIDTH_DEF      = 24;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int MANT_BITS            = 30;
  localparam int SQ_WIDTH             = 2 * MANT_BITS + 2;
  localparam int ROOT_WIDTH           = MANT_BITS + 1;
  localparam int OUT_WIDTH            = 16;

endpackage

### rtl/core/tfn_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
module tfn_sqrt_pipe #(
  parameter int SB_WIDTH = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [tfn_pkg::SQ_WIDTH-1:0]    in_sq,
  input  logic [SB_WIDTH-1:0]             in_sb,
  output logic                            out_vld,
  output logic [tfn_pkg::ROOT_WIDTH-1:0]  out_root,
  output logic [SB_WIDTH-1:0]             out_sb
);

  localparam int SW    = tfn_pkg::SQ_WIDTH;
  localparam int RW    = tfn_pkg::ROOT_WIDTH;
  localparam int RMW   = RW + 3;
  localparam int STEPS = RW;

  logic           vld_r [1:STEPS];
  logic [RMW-1:0] rem_r [1:STEPS];
  logic [RW-1:0]  q_r   [1:STEPS];
  logic [SW-1:0]  sq_r  [1:STEPS];
  logic [SB_WIDTH-1:0] sb_r [1:STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic           vld_in;
    logic [RMW-1:0] rem_in;
    logic [RW-1:0]  q_in;
    logic [SW-1:0]  sq_in;
    logic [SB_WIDTH-1:0] sb_in;
    logic [RMW-1:0] t;
    logic [RMW-1:0] trial;
    logic           ge;
    logic [RMW-1:0] rem_nxt;
    logic [RW-1:0]  q_nxt;

    if (k == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = '0;
      assign q_in   = '0;
      assign sq_in  = in_sq;
      assign sb_in  = in_sb;
    end else begin : g_rest
      assign vld_in = vld_r[k];
      assign rem_in = rem_r[k];
      assign q_in   = q_r[k];
      assign sq_in  = sq_r[k];
      assign sb_in  = sb_r[k];
    end

    always_comb begin
      t       = RMW'({rem_in, sq_in[SW-1-2*k -: 2]});
      trial   = RMW'({q_in, 2'b01});
      ge      = (t >= trial);
      rem_nxt = ge ? (t - trial) : t;
      q_nxt   = RW'({q_in, ge});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        q_r[k+1]   <= q_nxt;
        sq_r[k+1]  <= sq_in;
        sb_r[k+1]  <= sb_in;
      end
    end
  end

  assign out_vld  = vld_r[STEPS];
  assign out_root = q_r[STEPS];
  assign out_sb   = sb_r[STEPS];

endmodule

### rtl/core/tfn_div_lane.sv
// Pipelined restoring divider that scales one component by the vector length.
module tfn_div_lane #(
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [tfn_pkg::MANT_BITS-1:0]   in_mant,
  input  logic [tfn_pkg::ROOT_WIDTH-1:0]  in_len,
  output logic [NORMAL_FRAC_BITS:0]       out_quot
);

  localparam int MB = tfn_pkg::MANT_BITS;
  localparam int RW = tfn_pkg::ROOT_WIDTH;
  localparam int NF = NORMAL_FRAC_BITS;
  localparam int DL = NF + 1;
  localparam int NW = MB + NF + 1;

  logic [NW-1:0] num;

  logic [RW-1:0] rem_r [1:DL];
  logic [DL-1:0] q_r   [1:DL];
  logic [DL-1:0] low_r [1:DL];
  logic [RW-1:0] len_r [1:DL];

  assign num = NW'({in_mant, {NF{1'b0}}}) + NW'(in_len >> 1);

  for (genvar k = 0; k < DL; k++) begin : g_step
    logic [RW-1:0] rem_in;
    logic [DL-1:0] q_in;
    logic [DL-1:0] low_in;
    logic [RW-1:0] len_in;
    logic [RW:0]   t;
    logic          ge;
    logic [RW-1:0] rem_nxt;
    logic [DL-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign rem_in = RW'(num[NW-1:NF+1]);
      assign q_in   = '0;
      assign low_in = num[NF:0];
      assign len_in = in_len;
    end else begin : g_rest
      assign rem_in = rem_r[k];
      assign q_in   = q_r[k];
      assign low_in = low_r[k];
      assign len_in = len_r[k];
    end

    always_comb begin
      t       = {rem_in, low_in[DL-1]};
      ge      = (t >= {1'b0, len_in});
      rem_nxt = ge ? RW'(t - {1'b0, len_in}) : RW'(t);
      q_nxt   = DL'({q_in, ge});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= rem_nxt;
        q_r[k+1]   <= q_nxt;
        low_r[k+1] <= DL'({low_in, 1'b0});
        len_r[k+1] <= len_in;
      end
    end
  end

  assign out_quot = q_r[DL];

endmodule

### rtl/core/triangle_face_normal_top.sv
// Triangle face normal: edge cross product scaled to a unit vector.
// One word is accepted every cycle unless the output stalls; the square root and divider pipelines set the depth.
// A stall at the output freezes every stage; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
module triangle_face_normal_top #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [COORD_WIDTH-1:0]          in_a_x,
  input  logic signed [COORD_WIDTH-1:0]          in_a_y,
  input  logic signed [COORD_WIDTH-1:0]          in_a_z,
  input  logic signed [COORD_WIDTH-1:0]          in_b_x,
  input  logic signed [COORD_WIDTH-1:0]          in_b_y,
  input  logic signed [COORD_WIDTH-1:0]          in_b_z,
  input  logic signed [COORD_WIDTH-1:0]          in_c_x,
  input  logic signed [COORD_WIDTH-1:0]          in_c_y,
  input  logic signed [COORD_WIDTH-1:0]          in_c_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0]   out_norm_x,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0]   out_norm_y,
  output logic signed [tfn_pkg::OUT_WIDTH-1:0]   out_norm_z,
  output logic                                   out_degenerate
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int XW   = PW + 1;
  localparam int MB   = tfn_pkg::MANT_BITS;
  localparam int SQW  = 2 * MB;
  localparam int SW   = tfn_pkg::SQ_WIDTH;
  localparam int RW   = tfn_pkg::ROOT_WIDTH;
  localparam int MW   = $clog2(XW + 1);
  localparam int NG   = (XW + 7) / 8;
  localparam int GW   = $clog2(NG);
  localparam int SHW  = XW + MB;
  localparam int NF   = NORMAL_FRAC_BITS;
  localparam int DL   = NF + 1;
  localparam int SBW  = 3 * MB + 4;
  localparam int OXW  = 33;
  localparam int OW   = tfn_pkg::OUT_WIDTH;

  logic en;

  logic                 v1_r;
  logic signed [EW-1:0] e_r [3];
  logic signed [EW-1:0] f_r [3];

  logic                 v2_r;
  logic signed [PW-1:0] p_r [6];

  logic                 v3_r;
  logic signed [XW-1:0] c_r [3];

  logic                 v4_r;
  logic [XW-1:0]        mag_r [3];
  logic [2:0]           neg4_r;

  logic                 v5_r;
  logic [XW-1:0]        mag5_r [3];
  logic [2:0]           neg5_r;
  logic [MW-1:0]        m_r;

  logic                 v6_r;
  logic [MB-1:0]        r6_r [3];
  logic [2:0]           neg6_r;
  logic                 deg6_r;

  logic                 v7_r;
  logic [MB-1:0]        r7_r [3];
  logic [SQW-1:0]       sq_r [3];
  logic [2:0]           neg7_r;
  logic                 deg7_r;

  logic                 v8_r;
  logic [MB-1:0]        r8_r [3];
  logic [SW-1:0]        s_r;
  logic [2:0]           neg8_r;
  logic                 deg8_r;

  logic                 sq_vld;
  logic [RW-1:0]        sq_root;
  logic [SBW-1:0]       sq_sb;
  logic [MB-1:0]        dr     [3];
  logic [2:0]           dneg;
  logic                 ddeg;
  logic [DL-1:0]        quot   [3];

  logic                 dv_r   [DL];
  logic [2:0]           dneg_r [DL];
  logic                 ddeg_r [DL];

  logic                 out_valid_r;
  logic [OW-1:0]        norm_r [3];
  logic                 deg_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Edges from the first vertex, their products and the cross product components.
  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= $signed({in_b_x[CW-1], in_b_x}) - $signed({in_a_x[CW-1], in_a_x});
      e_r[1] <= $signed({in_b_y[CW-1], in_b_y}) - $signed({in_a_y[CW-1], in_a_y});
      e_r[2] <= $signed({in_b_z[CW-1], in_b_z}) - $signed({in_a_z[CW-1], in_a_z});
      f_r[0] <= $signed({in_c_x[CW-1], in_c_x}) - $signed({in_a_x[CW-1], in_a_x});
      f_r[1] <= $signed({in_c_y[CW-1], in_c_y}) - $signed({in_a_y[CW-1], in_a_y});
      f_r[2] <= $signed({in_c_z[CW-1], in_c_z}) - $signed({in_a_z[CW-1], in_a_z});
      p_r[0] <= e_r[1] * f_r[2];
      p_r[1] <= e_r[2] * f_r[1];
      p_r[2] <= e_r[2] * f_r[0];
      p_r[3] <= e_r[0] * f_r[2];
      p_r[4] <= e_r[0] * f_r[1];
      p_r[5] <= e_r[1] * f_r[0];
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= $signed({p_r[2*i][PW-1], p_r[2*i]})
                - $signed({p_r[2*i+1][PW-1], p_r[2*i+1]});
      end
    end
  end

  // Sign and magnitude of each cross product component.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i]  <= c_r[i][XW-1] ? ($unsigned(~c_r[i]) + XW'(1)) : $unsigned(c_r[i]);
        neg4_r[i] <= c_r[i][XW-1];
      end
    end
  end

  // Bit length of the largest magnitude, found per byte group.
  logic [XW-1:0]   or_all;
  logic [NG*8-1:0] or_pad;
  logic [GW-1:0]   gsel;
  logic            g_any;
  logic [7:0]      gbyte;
  logic [2:0]      bpos;
  logic [MW-1:0]   m_nxt;

  always_comb begin
    or_all = mag_r[0] | mag_r[1] | mag_r[2];
    or_pad = (NG*8)'(or_all);
    gsel   = '0;
    g_any  = 1'b0;
    for (int g = 0; g < NG; g++) begin
      if (|or_pad[8*g +: 8]) begin
        gsel  = GW'(g);
        g_any = 1'b1;
      end
    end
    gbyte = or_pad[8*gsel +: 8];
    bpos  = '0;
    for (int b = 0; b < 8; b++) begin
      if (gbyte[b]) begin
        bpos = 3'(b);
      end
    end
    m_nxt = g_any ? MW'({gsel, bpos} + 1) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag5_r <= mag_r;
      neg5_r <= neg4_r;
      m_r    <= m_nxt;
    end
  end

  // Normalize so that the largest magnitude has exactly MANT_BITS bits.
  logic [MB-1:0] r_nxt [3];
  logic [7:0]    rsh;
  logic [7:0]    lsh;

  always_comb begin
    rsh = 8'(m_r) - 8'(MB);
    lsh = 8'(MB) - 8'(m_r);
    for (int i = 0; i < 3; i++) begin
      if (8'(m_r) > 8'(MB)) begin
        r_nxt[i] = MB'(SHW'(mag5_r[i]) >> rsh);
      end else begin
        r_nxt[i] = MB'(SHW'(mag5_r[i]) << lsh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r6_r   <= r_nxt;
      neg6_r <= neg5_r;
      deg6_r <= (m_r == '0);
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= r6_r[i] * r6_r[i];
      end
      r7_r   <= r6_r;
      neg7_r <= neg6_r;
      deg7_r <= deg6_r;
      s_r    <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      r8_r   <= r7_r;
      neg8_r <= neg7_r;
      deg8_r <= deg7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  tfn_sqrt_pipe #(
    .SB_WIDTH (SBW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v8_r),
    .in_sq    (s_r),
    .in_sb    ({r8_r[0], r8_r[1], r8_r[2], neg8_r, deg8_r}),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_sb   (sq_sb)
  );

  assign {dr[0], dr[1], dr[2], dneg, ddeg} = sq_sb;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tfn_div_lane #(
      .NORMAL_FRAC_BITS (NF)
    ) u_div (
      .clk      (clk),
      .en       (en),
      .in_mant  (dr[i]),
      .in_len   (sq_root),
      .out_quot (quot[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DL; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else if (en) begin
      dv_r[0] <= sq_vld;
      for (int k = 1; k < DL; k++) begin
        dv_r[k] <= dv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dneg_r[0] <= dneg;
      ddeg_r[0] <= ddeg;
      for (int k = 1; k < DL; k++) begin
        dneg_r[k] <= dneg_r[k-1];
        ddeg_r[k] <= ddeg_r[k-1];
      end
    end
  end

  // Clamp to one, apply the sign, zero degenerate results and keep the low output bits.
  logic [DL-1:0]  qc   [3];
  logic [OXW-1:0] qx   [3];
  logic [OXW-1:0] sv   [3];
  logic [OW-1:0]  n_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i]    = (quot[i] > (DL'(1) << NF)) ? (DL'(1) << NF) : quot[i];
      qx[i]    = OXW'(qc[i]);
      sv[i]    = dneg_r[DL-1][i] ? (~qx[i] + OXW'(1)) : qx[i];
      n_nxt[i] = ddeg_r[DL-1] ? '0 : sv[i][OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      norm_r <= n_nxt;
      deg_r  <= ddeg_r[DL-1];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_norm_x     = $signed(norm_r[0]);
  assign out_norm_y     = $signed(norm_r[1]);
  assign out_norm_z     = $signed(norm_r[2]);
  assign out_degenerate = deg_r;

endmodule

### rtl/core/tfn_checker.sv
// Port-level checks for the triangle face normal block, bound to the top level.
module tfn_checker #(
  parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic signed [COORD_WIDTH-1:0]         in_a_x,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [tfn_pkg::OUT_WIDTH-1:0]  out_norm_x,
  input logic signed [tfn_pkg::OUT_WIDTH-1:0]  out_norm_y,
  input logic signed [tfn_pkg::OUT_WIDTH-1:0]  out_norm_z,
  input logic                                  out_degenerate
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_a_x))
    else $error("input word changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_norm_x)
      && $stable(out_norm_y) && $stable(out_norm_z) && $stable(out_degenerate))
    else $error("result word changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output register is empty");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_norm_x == '0 && out_norm_y == '0
      && out_norm_z == '0)
    else $error("degenerate result carries a nonzero normal");

endmodule

bind triangle_face_normal_top tfn_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tfn_checker (.*);
